FILE: src/lk2fp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lk2fp_pkg: shared types and constants of the lookup2 fingerprint block
// Beat formats, queue entry format and the fixed lookup2 constants.
// ----------------------------------------------------------------------------
package lk2fp_pkg;

	// Message block geometry.
	localparam int unsigned BLOCK_LEN = 12;
	localparam int unsigned POS_W     = 4;

	// Mix schedule: nine subtract/xor rounds, one per cycle.
	localparam int unsigned MIX_STEPS = 9;
	localparam int unsigned STEP_W    = 4;

	// Job queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	// Register port.
	localparam int unsigned ADDR_W   = 3;
	localparam logic [0:0]  REG_SEED = 1'b0;

	// lookup2 constants.
	localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
	localparam logic [31:0] LOW_SEED   = 32'h00007a63;
	localparam logic [31:0] SEED_RESET = 32'h00006d6f;
	localparam logic [63:0] AVOID_XOR  = 64'h130f9bef94a0a928;

	// Input beat.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_t;

	// Output beat.
	typedef struct packed {
		logic [63:0] fingerprint;
		logic [31:0] hash32;
	} out_t;

	// Work handed from front to back. A job mixes one full block (blk),
	// finishes a message (fin), or both in that order.
	typedef struct packed {
		logic        start;
		logic        blk;
		logic        fin;
		logic [31:0] seed;
		logic [31:0] len;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
	} job_t;

endpackage
`default_nettype wire

FILE: src/lk2fp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lk2fp_queue: job queue
// Small first-in first-out buffer that decouples the byte front end from
// the mixing back end.
// ----------------------------------------------------------------------------
module lk2fp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lk2fp_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          pop,
	output lk2fp_pkg::job_t    rd_job,
	output logic               empty
);
	import lk2fp_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The front end must never overrun the queue, nor the back end drain it dry.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("job pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job popped from an empty queue");

endmodule
`default_nettype wire

FILE: src/lk2fp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lk2fp_front: byte front end
// Accepts one byte beat per cycle while the queue has room, gathers 12-byte
// blocks, counts the message length, builds block and end-of-message jobs.
// ----------------------------------------------------------------------------
module lk2fp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire lk2fp_pkg::in_t in_data,
	input  wire logic [31:0]    seed,
	output logic                push,
	output lk2fp_pkg::job_t     job,
	input  wire logic           full
);
	import lk2fp_pkg::*;

	logic [7:0]       bytes_q [BLOCK_LEN];
	logic [POS_W-1:0] pos_q;
	logic [31:0]      len_q;
	logic             first_q;
	logic [31:0]      seed_msg_q;

	logic             accept;
	logic             blk;
	logic [POS_W-1:0] pos_after;
	logic [31:0]      len_next;
	logic [31:0]      seed_use;
	logic [7:0]       cur  [BLOCK_LEN];
	logic [7:0]       tail [BLOCK_LEN];

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// Block position and length after this beat.
	assign blk       = in_data.has_byte && (pos_q == POS_W'(BLOCK_LEN - 1));
	assign pos_after = blk ? '0 : (in_data.has_byte ? pos_q + 1'b1 : pos_q);
	assign len_next  = len_q + 32'(in_data.has_byte);

	// A message takes the seed that is current when its first byte arrives.
	assign seed_use = (len_q == '0) ? seed : seed_msg_q;

	// Block view with the incoming byte merged in, and its masked tail.
	always_comb begin
		for (int k = 0; k < BLOCK_LEN; k++) begin
			cur[k]  = (in_data.has_byte && (pos_q == POS_W'(k))) ? in_data.data_byte
				: bytes_q[k];
			tail[k] = (POS_W'(k) < pos_after) ? cur[k] : 8'h00;
		end
	end

	// Job assembly.
	always_comb begin
		job.start = first_q;
		job.blk   = blk;
		job.fin   = in_data.is_last;
		job.seed  = seed_use;
		job.len   = len_next;
		if (blk) begin
			job.w0 = {cur[3], cur[2], cur[1], cur[0]};
			job.w1 = {cur[7], cur[6], cur[5], cur[4]};
			job.w2 = {cur[11], cur[10], cur[9], cur[8]};
		end else begin
			job.w0 = {tail[3], tail[2], tail[1], tail[0]};
			job.w1 = {tail[7], tail[6], tail[5], tail[4]};
			job.w2 = {tail[10], tail[9], tail[8], 8'h00} + len_next;
		end
	end

	assign push = accept && (blk || in_data.is_last);

	// Byte storage.
	always_ff @(posedge clk) begin
		if (accept && in_data.has_byte) begin
			bytes_q[pos_q] <= in_data.data_byte;
			seed_msg_q     <= seed_use;
		end
	end

	// Message tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (in_data.is_last) begin
				pos_q   <= '0;
				len_q   <= '0;
				first_q <= 1'b1;
			end else begin
				pos_q <= pos_after;
				len_q <= len_next;
				if (blk) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(BLOCK_LEN))
		else $error("block position out of range");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.is_last) |=> (pos_q == '0 && len_q == '0 && first_q))
		else $error("message state not cleared after end of message");

endmodule
`default_nettype wire

FILE: src/lk2fp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lk2fp_back: mixing back end
// Holds both lookup2 lanes, adds each job's words, runs the mix one round
// per cycle and registers the finished fingerprint.
// ----------------------------------------------------------------------------
module lk2fp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	input  wire lk2fp_pkg::job_t job,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lk2fp_pkg::out_t      out_data
);
	import lk2fp_pkg::*;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lane_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_MIX  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// One round of the lookup2 mix; rounds run in order 0 to 8.
	function automatic lane_t mix_step(input lane_t l, input logic [STEP_W-1:0] k);
		lane_t r;
		r = l;
		unique case (k)
			4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
			4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
			4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
			4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
			4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
			4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
			4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
			4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
			4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
			default: r = l;
		endcase
		return r;
	endfunction

	state_t            state_q;
	job_t              job_q;
	logic              phase_fin_q;
	logic [STEP_W-1:0] step_q;
	lane_t             hi_q;
	lane_t             lo_q;
	logic              out_valid_q;
	out_t              out_q;

	logic  use_init;
	lane_t hi_base;
	lane_t lo_base;
	lane_t add_w;
	logic  emit_load;
	logic  [63:0] fp;

	assign pop       = (state_q == ST_IDLE) && job_valid;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Lane start values and the words added at the start of a phase.
	always_comb begin
		use_init = job_q.start && (!phase_fin_q || !job_q.blk);
		hi_base  = use_init ? lane_t'{GOLDEN, GOLDEN, job_q.seed} : hi_q;
		lo_base  = use_init ? lane_t'{GOLDEN, GOLDEN, LOW_SEED} : lo_q;
		if (phase_fin_q && job_q.blk) begin
			add_w = lane_t'{32'h0, 32'h0, job_q.len};
		end else begin
			add_w = lane_t'{job_q.w0, job_q.w1, job_q.w2};
		end
	end

	// Final fingerprint with the reserved-value fixup.
	always_comb begin
		fp = {hi_q.c, lo_q.c};
		if (hi_q.c == '0 && lo_q.c < 32'd2) begin
			fp = fp ^ AVOID_XOR;
		end
	end

	// Job payload and lane registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (state_q == ST_LOAD) begin
			hi_q.a <= hi_base.a + add_w.a;
			hi_q.b <= hi_base.b + add_w.b;
			hi_q.c <= hi_base.c + add_w.c;
			lo_q.a <= lo_base.a + add_w.a;
			lo_q.b <= lo_base.b + add_w.b;
			lo_q.c <= lo_base.c + add_w.c;
		end else if (state_q == ST_MIX) begin
			hi_q <= mix_step(hi_q, step_q);
			lo_q <= mix_step(lo_q, step_q);
		end
		if (emit_load) begin
			out_q.fingerprint <= fp;
			out_q.hash32      <= hi_q.c;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_fin_q <= 1'b0;
			step_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						phase_fin_q <= !job.blk;
						state_q     <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (step_q == STEP_W'(MIX_STEPS - 1)) begin
						step_q <= '0;
						if (!phase_fin_q && job_q.fin) begin
							phase_fin_q <= 1'b1;
							state_q     <= ST_LOAD;
						end else if (phase_fin_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MIX) |-> (step_q == '0))
		else $error("mix round counter active outside the mix state");

endmodule
`default_nettype wire

FILE: src/lookup2_fingerprint64.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lookup2_fingerprint64: two-lane lookup2 64-bit fingerprint
// Streams message bytes through two Jenkins lookup2 lanes, one seeded by
// a register and one by a fixed seed, and returns a 64-bit fingerprint.
//
//   Port group   Direction  Beat contents
//   in_*         input      data_byte, has_byte, is_last
//   out_*        output     fingerprint, hash32 (one beat per message)
//   APB p*       register   seed_high at byte address 0
//
// A byte beat is taken every cycle while the four-entry job queue has room.
// Per job the back end pops, adds the words and runs nine mix rounds, then
// emits if it ends a message; one that also closes a block adds and mixes
// twice. The back end's one-round-per-cycle mix unit sets the sustained rate.
// Reset clears all control state; seed_high returns to 0x6d6f.
// A stalled output holds its beat in the output register; the back end and
// then the queue fill, after which in_ready drops.
// ----------------------------------------------------------------------------
module lookup2_fingerprint64 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire lk2fp_pkg::in_t               in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lk2fp_pkg::out_t                   out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lk2fp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import lk2fp_pkg::*;

	logic [31:0] seed_q;
	logic        reg_hit;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	job_t        q_wr_job;
	job_t        q_rd_job;

	// Register port.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_SEED);
	assign prdata  = reg_hit ? seed_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			seed_q <= pwdata;
		end
	end

	lk2fp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.seed     (seed_q),
		.push     (q_push),
		.job      (q_wr_job),
		.full     (q_full)
	);

	lk2fp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (q_wr_job),
		.full   (q_full),
		.pop    (q_pop),
		.rd_job (q_rd_job),
		.empty  (q_empty)
	);

	lk2fp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (q_rd_job),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-lane lookup2 fingerprint block
// Feeds byte beats through the valid/ready input, predicts both hash lanes
// in an independent model kept in the bench, and compares every result beat
// field by field. Seed writes go through the APB port between phases, and
// both sides of the stream pause and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import lk2fp_pkg::*;

	// Run control.
	localparam int          RUN_LIMIT     = 400000;
	localparam int          SETTLE_CYCLES = 120;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          RANDOM_BEATS  = 310;
	localparam logic [31:0] FP_SEED       = 32'hfd12deff;

	// Register map: seed_high at index 0; index 1 decodes to nothing.
	localparam logic [ADDR_W-1:0] SEED_ADDR   = {REG_SEED, 2'b00};
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = 3'b100;

	typedef enum logic {RX_OPEN, RX_CHOPPY} rx_mode_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lane_t;

	// Block ports.
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_t               in_data  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Hash state as the block should hold it.
	logic [31:0] seed_reg;
	lane_t       hi_lane;
	lane_t       lo_lane;
	logic [7:0]  block_buf [BLOCK_LEN];
	int          block_pos;
	logic [31:0] msg_len;

	// Fingerprints still owed by the block, oldest first.
	out_t fp_due [$];
	out_t fp_want;

	// Pacing of both sides.
	int       gap_max   = 0;
	int       burst_max = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode   = RX_OPEN;
	bit       hold_req  = 1'b0;
	int       stall_left = 0;

	// Bookkeeping.
	int n_errors      = 0;
	int n_checked     = 0;
	int n_beats       = 0;
	int n_bytes       = 0;
	int n_seed_writes = 0;
	int cycle_count   = 0;

	lookup2_fingerprint64 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Free-running clock, 8 ns period.
	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still owed", $time,
				cycle_count, fp_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The lookup2 mix: nine subtract, subtract, xor-shift rounds.
	function automatic lane_t mix_lane(input lane_t s);
		logic [31:0] a, b, c;
		a = s.a;
		b = s.b;
		c = s.c;
		a = (a - b - c) ^ (c >> 13);
		b = (b - c - a) ^ (a << 8);
		c = (c - a - b) ^ (b >> 13);
		a = (a - b - c) ^ (c >> 12);
		b = (b - c - a) ^ (a << 16);
		c = (c - a - b) ^ (b >> 5);
		a = (a - b - c) ^ (c >> 3);
		b = (b - c - a) ^ (a << 10);
		c = (c - a - b) ^ (b >> 15);
		return '{a: a, b: b, c: c};
	endfunction

	// Adds three words into a lane and mixes it.
	function automatic lane_t absorb(input lane_t s, input logic [31:0] w0,
		input logic [31:0] w1, input logic [31:0] w2);
		return mix_lane('{a: s.a + w0, b: s.b + w1, c: s.c + w2});
	endfunction

	// Little-endian word of the filled bytes from index first on, at most four.
	function automatic logic [31:0] tail_word(input int first, input int fill);
		int          n;
		logic [31:0] w;
		n = fill - first;
		if (n < 0) n = 0;
		if (n > 4) n = 4;
		w = '0;
		for (int k = 0; k < n; k++) w |= 32'(block_buf[first + k]) << (8 * k);
		return w;
	endfunction

	// Both lanes back to their starting values; the high lane takes the seed.
	function automatic void restart_message();
		hi_lane   = '{a: GOLDEN, b: GOLDEN, c: seed_reg};
		lo_lane   = '{a: GOLDEN, b: GOLDEN, c: LOW_SEED};
		block_pos = 0;
		msg_len   = '0;
	endfunction

	// Folds one accepted beat into the hash state and, at the end of a
	// message, queues the fingerprint the block owes.
	function automatic void fold_beat(input in_t beat);
		logic [31:0] w0, w1, w2, hi, lo;
		logic [63:0] fp;
		if (beat.has_byte) begin
			block_buf[block_pos] = beat.data_byte;
			block_pos++;
			msg_len++;
			if (block_pos == BLOCK_LEN) begin
				w0 = tail_word(0, BLOCK_LEN);
				w1 = tail_word(4, BLOCK_LEN);
				w2 = tail_word(8, BLOCK_LEN);
				hi_lane   = absorb(hi_lane, w0, w1, w2);
				lo_lane   = absorb(lo_lane, w0, w1, w2);
				block_pos = 0;
			end
		end
		if (beat.is_last) begin
			// Leftover bytes plus the length; c's bytes sit one byte up.
			w0 = tail_word(0, block_pos);
			w1 = tail_word(4, block_pos);
			w2 = (tail_word(8, block_pos) << 8) + msg_len;
			hi_lane = absorb(hi_lane, w0, w1, w2);
			lo_lane = absorb(lo_lane, w0, w1, w2);
			hi = hi_lane.c;
			lo = lo_lane.c;
			fp = {hi, lo};
			if (hi == '0 && lo < 32'd2) fp ^= AVOID_XOR;
			fp_due.push_back('{fingerprint: fp, hash32: hi});
			restart_message();
		end
	endfunction

	// Sender pacing: bursts of random length with random gaps between them.
	task automatic sender_pause();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, burst_max);
		end
	endtask

	// Offers one beat and holds it until the block takes it.
	task automatic send_beat(input in_t beat);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		fold_beat(beat);
		if (beat.has_byte || beat.is_last) n_beats++;
		if (beat.has_byte) n_bytes++;
		sender_pause();
	endtask

	// Sends a message of len random bytes. With close_empty the end comes
	// on an extra beat that carries no byte; an empty message always does.
	task automatic send_message(input int len, input bit close_empty, input bit with_idle);
		in_t beat;
		for (int i = 0; i < len; i++) begin
			if (with_idle && $urandom_range(0, 19) == 0) begin
				beat = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, is_last: 1'b0};
				send_beat(beat);
			end
			beat.data_byte = 8'($urandom_range(0, 255));
			beat.has_byte  = 1'b1;
			beat.is_last   = (i == len - 1) && !close_empty;
			send_beat(beat);
		end
		if (close_empty || len == 0) begin
			beat = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, is_last: 1'b1};
			send_beat(beat);
		end
	endtask

	// Stops sending, waits for every owed result, then lets the back end
	// finish any block mix that produces no result.
	task automatic wait_results();
		in_valid <= 1'b0;
		while (fp_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write; the register takes it at the access edge.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == SEED_ADDR) begin
			seed_reg = value;
			if (msg_len == '0) hi_lane.c = seed_reg;
			n_seed_writes++;
		end
	endtask

	// Reads seed_high back and compares it with the expected value. The
	// bus is left idle first, so a transfer just before ends.
	task automatic check_seed();
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= SEED_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== seed_reg) begin
			n_errors++;
			$display("%0t: seed_high readback mismatch: expected %h, got %h", $time,
				seed_reg, got);
		end
	endtask

	// Register write with the block idle, followed by a readback.
	task automatic set_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		wait_results();
		write_reg(addr, value);
		check_seed();
	endtask

	// Receiver: stalls on its own random pattern, or holds off for a long
	// stretch when a test asks for it.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (rx_mode == RX_CHOPPY && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 11);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker: each result beat against the oldest owed fingerprint.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (fp_due.size() == 0) begin
				n_errors++;
				$display("%0t: result beat with none owed: expected nothing, got %h / %h",
					$time, out_data.fingerprint, out_data.hash32);
			end else begin
				fp_want = fp_due.pop_front();
				n_checked++;
				if (out_data.fingerprint !== fp_want.fingerprint) begin
					n_errors++;
					$display("%0t: fingerprint mismatch: expected %h, got %h", $time,
						fp_want.fingerprint, out_data.fingerprint);
				end
				if (out_data.hash32 !== fp_want.hash32) begin
					n_errors++;
					$display("%0t: hash32 mismatch: expected %h, got %h", $time,
						fp_want.hash32, out_data.hash32);
				end
			end
		end
	end

	// Reset value of the seed, then short hand-made messages under it.
	task automatic test_directed_messages();
		logic [7:0] pattern [12];
		in_t        beat;
		pattern = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe,
			8'h55, 8'haa, 8'h0f, 8'hf0, 8'hff, 8'h00};
		gap_max = 0;
		rx_mode = RX_OPEN;
		check_seed();
		// Empty message, then an idle beat that must leave no trace.
		send_beat('{data_byte: 8'hff, has_byte: 1'b0, is_last: 1'b1});
		send_beat('{data_byte: 8'h00, has_byte: 1'b0, is_last: 1'b0});
		// A one-byte message with the top byte value.
		send_beat('{data_byte: 8'hff, has_byte: 1'b1, is_last: 1'b1});
		// Exactly one block, closed on its twelfth byte.
		for (int i = 0; i < 12; i++) begin
			beat = '{data_byte: pattern[i], has_byte: 1'b1, is_last: (i == 11)};
			send_beat(beat);
		end
		// Three bytes closed by a beat that carries no byte.
		send_message(3, 1'b1, 1'b0);
		wait_results();
	endtask

	// Seed extremes, the fingerprint seed, and a write to an unused address.
	task automatic test_seed_settings();
		logic [31:0] seeds [3];
		seeds   = '{32'h0000_0000, 32'hffff_ffff, FP_SEED};
		gap_max = 3;
		burst_max = 4;
		rx_mode = RX_CHOPPY;
		foreach (seeds[i]) begin
			set_reg(SEED_ADDR, seeds[i]);
			send_message(0, 1'b1, 1'b0);
			send_message(11, 1'b0, 1'b0);
			send_message(13, 1'b1, 1'b0);
		end
		set_reg(UNUSED_ADDR, $urandom);
		send_message(5, 1'b0, 1'b0);
		wait_results();
	endtask

	// A seed written mid-message applies only from the next message on.
	task automatic test_seed_mid_message();
		gap_max = 0;
		rx_mode = RX_OPEN;
		// Five bytes with no end, so the message stays open.
		for (int i = 0; i < 5; i++)
			send_beat('{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b1,
				is_last: 1'b0});
		wait_results();
		write_reg(SEED_ADDR, $urandom);
		check_seed();
		// Continue the same message and close it.
		for (int i = 0; i < 8; i++)
			send_beat('{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b1,
				is_last: (i == 7)});
		send_message(0, 1'b1, 1'b0);
		send_message(7, 1'b0, 1'b0);
		wait_results();
	endtask

	// The receiver holds off while the sender keeps going, so the block
	// fills up and backs up into its input.
	task automatic test_output_holdoff();
		gap_max = 0;
		rx_mode = RX_OPEN;
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++) send_message($urandom_range(0, 14), 1'b0, 1'b0);
		wait_results();
	endtask

	// Random messages in phases with differing pacing and seeds.
	task automatic test_random_traffic();
		int          start_beats;
		int          msg_count;
		int          len;
		logic [31:0] seed;
		start_beats = n_beats;
		msg_count   = 0;
		while (n_beats - start_beats < RANDOM_BEATS) begin
			if (msg_count % 12 == 0) begin
				case ((msg_count / 12) % 4)
					0: begin
						gap_max = 0;  burst_max = 0;  rx_mode = RX_OPEN;
					end
					1: begin
						gap_max = 4;  burst_max = 6;  rx_mode = RX_CHOPPY;
					end
					2: begin
						gap_max = 12; burst_max = 2;  rx_mode = RX_CHOPPY;
					end
					default: begin
						gap_max = 2;  burst_max = 20; rx_mode = RX_OPEN;
					end
				endcase
				if (msg_count > 0) begin
					case ($urandom_range(0, 5))
						0:       seed = 32'h0000_0000;
						1:       seed = 32'hffff_ffff;
						2:       seed = FP_SEED;
						default: seed = $urandom;
					endcase
					set_reg(SEED_ADDR, seed);
				end
			end
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 26) : $urandom_range(27, 60);
			send_message(len, $urandom_range(0, 3) == 0, 1'b1);
			msg_count++;
		end
		wait_results();
	endtask

	// Main sequence.
	initial begin
		seed_reg = SEED_RESET;
		restart_message();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_messages();
		test_seed_settings();
		test_seed_mid_message();
		test_output_holdoff();
		test_random_traffic();

		wait_results();
		$display("Hashed %0d bytes in %0d beats; %0d fingerprints compared.",
			n_bytes, n_beats, n_checked);
		$display("Seed written %0d times, with extremes, mid-message writes and backpressure.",
			n_seed_writes);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/lk2fp_pkg.sv
src/lk2fp_queue.sv
src/lk2fp_front.sv
src/lk2fp_back.sv
src/lookup2_fingerprint64.sv
test/testbench.sv
